[design/fwc_pkg.sv]
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared types and constants for the four-way cache lookup and fill core.
// ----------------------------------------------------------------------------
`default_nettype none

package fwc_pkg;

    localparam int LINES     = 4;
    localparam int ADDR_BITS = 16;
    localparam int WAYS      = 4;
    localparam int WAY_W     = 2;
    localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int S_ADDR_W  = 16;
    localparam int S_VICT_W  = 2;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 8;

    typedef logic [ADDR_BITS-1:0]      tag_t;
    typedef tag_t [WAYS-1:0]           tag_row_t;
    typedef logic [WAYS-1:0]           way_mask_t;
    typedef logic [LINE_W-1:0]         line_t;
    typedef logic [WAY_W-1:0]          way_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic hit;
        way_t way;
    } sel_t;

endpackage

`default_nettype wire

[design/fwc_way_select.sv]
// ----------------------------------------------------------------------------
// fwc_way_select
// Compares the four ways of one line against the tag and picks the way:
// the lowest hitting way, else the lowest invalid way, else the victim.
// ----------------------------------------------------------------------------
`default_nettype none

module fwc_way_select
    import fwc_pkg::*;
(
    input  wire tag_row_t  row,
    input  wire way_mask_t valid,
    input  wire tag_t      tag,
    input  wire way_t      victim,
    output sel_t           sel
);

    logic      any_hit;
    logic      any_free;
    way_t      hit_way;
    way_t      free_way;

    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (valid[w] && (row[w] == tag)) begin
                any_hit = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid[w]) begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        sel.hit = any_hit;
        if (any_hit) begin
            sel.way = hit_way;
        end else if (any_free) begin
            sel.way = free_way;
        end else begin
            sel.way = victim;
        end
    end

endmodule

`default_nettype wire

[design/four_way_cache_lookup_fill_core.sv]
// ----------------------------------------------------------------------------
// four_way_cache_lookup_fill_core
// Four-way set-associative tag store with lookup and fill on miss.
// ----------------------------------------------------------------------------
// On acceptance of an item the line's tag row is read from a synchronous tag
// memory into rd_row_reg. In the lookup state the four ways are compared; once
// the output register is free, a miss writes the tag back into the chosen way
// and the result is registered. A new item is accepted as soon as the result
// is registered, even while it waits on m_tready; only a result still
// unclaimed when the next lookup finishes stalls the block. Valid bits are
// flops cleared by reset, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_cache_lookup_fill_core
    import fwc_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [S_DATA_W-1:0]  s_tdata,   // [15:0] address, [17:16] victim_way
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] hit, [2:1] way_used
);

    state_t    state_reg, state_next;
    tag_t      tag_reg;
    way_t      victim_reg;
    line_t     line_reg;
    way_mask_t valid_reg [LINES];
    tag_row_t  tag_mem [LINES];
    tag_row_t  rd_row_reg;
    logic      m_valid_reg;
    logic      m_hit_reg;
    way_t      m_way_reg;

    tag_t      s_tag;
    line_t     s_line;
    line_t     rd_line;
    logic      s_accept;
    logic      done;
    sel_t      sel;
    tag_row_t  wr_row;

    assign s_tag    = tag_t'(s_tdata[S_ADDR_W-1:0]);
    assign s_line   = LINE_W'(s_tag % LINES);
    assign s_accept = s_tvalid && s_tready;
    assign rd_line  = s_accept ? s_line : line_reg;

    fwc_way_select u_sel (
        .row    (rd_row_reg),
        .valid  (valid_reg[line_reg]),
        .tag    (tag_reg),
        .victim (victim_reg),
        .sel    (sel)
    );

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_tready) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wr_row          = rd_row_reg;
        wr_row[sel.way] = tag_reg;
    end

    always_ff @(posedge aclk) begin
        rd_row_reg <= tag_mem[rd_line];
        if (done && !sel.hit) begin
            tag_mem[line_reg] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                valid_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (done) begin
                m_valid_reg <= 1'b1;
                if (!sel.hit) begin
                    valid_reg[line_reg][sel.way] <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tag_reg    <= s_tag;
            line_reg   <= s_line;
            victim_reg <= s_tdata[S_ADDR_W +: S_VICT_W];
        end
        if (done) begin
            m_hit_reg <= sel.hit;
            m_way_reg <= sel.way;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - WAY_W - 1)'(0), m_way_reg, m_hit_reg};

endmodule

`default_nettype wire

[design/fwc_checker.sv]
// ----------------------------------------------------------------------------
// fwc_checker
// Port-level checks for the four-way cache lookup and fill core.
// ----------------------------------------------------------------------------
`default_nettype none

module fwc_checker
    import fwc_pkg::*;
(
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);

    logic s_acc;
    logic m_free;

    assign s_acc  = s_tvalid && s_tready;
    assign m_free = !m_tvalid || m_tready;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("item accepted during lookup");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && m_free |=> ##1 m_tvalid)
        else $error("result item late");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:WAY_W+1] == '0)
        else $error("result padding not zero");

endmodule

bind four_way_cache_lookup_fill_core fwc_checker u_fwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/tb_four_way_cache_lookup_fill_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_way_cache_lookup_fill_core
// Self-checking bench for the four-way cache lookup and fill core.
// ----------------------------------------------------------------------------
// A queue of accesses feeds a stream driver: a directed run through fills,
// hits and replacements, then random accesses drawn mostly from a small
// address pool so that lines fill up, hit and get replaced. Every accepted
// access updates a local copy of the tag store, which predicts hit and way.
// The monitor checks each result item against the oldest prediction. Both
// sides throttle at random; one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------

module tb_four_way_cache_lookup_fill_core;
    import fwc_pkg::*;

    localparam int CLK_HALF  = 6;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_LEN  = 80;

    typedef struct {
        tag_t addr;
        way_t victim;
    } access_t;

    typedef struct {
        logic hit;
        way_t way;
    } lookup_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;    // [15:0] address, [17:16] victim_way
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // [0] hit, [2:1] way_used

    access_t pending_accesses[$];
    lookup_t expected_lookups[$];

    logic way_valid [LINES][WAYS];
    tag_t way_tag   [LINES][WAYS];
    tag_t addr_pool [POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_block    = 1'b0;
    bit pressure_go   = 1'b0;
    bit s_fire        = 1'b0;
    int n_hits        = 0;
    int n_misses      = 0;
    int n_evicts      = 0;
    int n_results     = 0;
    int n_errors      = 0;

    four_way_cache_lookup_fill_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Look up one address in the local tag store and fill it on a miss.
    function automatic lookup_t lookup_fill(tag_t addr, way_t victim);
        lookup_t r;
        int      line_idx;
        bit      found;
        line_idx = int'(addr % LINES);
        r.hit    = 1'b0;
        r.way    = '0;
        found    = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && way_valid[line_idx][w] && way_tag[line_idx][w] == addr) begin
                r.hit = 1'b1;
                r.way = way_t'(w);
                found = 1'b1;
            end
        end
        if (r.hit) begin
            n_hits++;
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !way_valid[line_idx][w]) begin
                    r.way = way_t'(w);
                    found = 1'b1;
                end
            end
            if (!found) begin
                r.way = victim;
                n_evicts++;
            end
            way_valid[line_idx][r.way] = 1'b1;
            way_tag[line_idx][r.way]   = addr;
            n_misses++;
        end
        return r;
    endfunction

    // Monitor and predictor.
    always @(posedge aclk) begin
        lookup_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_lookups.size() == 0) begin
                    $error("result item with no access pending: m_tdata=%h", m_tdata);
                    n_errors++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
                        n_errors++;
                    end
                    if (m_tdata[2:1] !== want.way) begin
                        $error("way_used: expected %0d, got %0d", want.way, m_tdata[2:1]);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_lookups.push_back(lookup_fill(s_tdata[15:0], s_tdata[17:16]));
            end
        end
    end

    // Access driver.
    always @(negedge aclk) begin
        access_t nxt;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt      = pending_accesses.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_DATA_W-S_ADDR_W-S_VICT_W){1'b0}}, nxt.victim, nxt.addr};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver.
    always @(negedge aclk) begin
        if (recv_block) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        wait (pressure_go);
        recv_block = 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        recv_block = 1'b0;
    end

    task automatic push_access(tag_t addr, way_t victim);
        access_t a;
        a.addr   = addr;
        a.victim = victim;
        pending_accesses.push_back(a);
    endtask

    // Mostly pool addresses so lines fill, hit and get replaced.
    task automatic queue_random(int count);
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = tag_t'($urandom);
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) begin
                push_access(addr_pool[$urandom_range(POOL_SIZE-1)], way_t'($urandom_range(3)));
            end else begin
                push_access(tag_t'($urandom), way_t'($urandom_range(3)));
            end
        end
    endtask

    task automatic drain_accesses();
        while (pending_accesses.size() != 0 || s_tvalid) @(posedge aclk);
    endtask

    initial begin
        for (int l = 0; l < LINES; l++) begin
            for (int w = 0; w < WAYS; w++) begin
                way_valid[l][w] = 1'b0;
                way_tag[l][w]   = '0;
            end
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 74;
        // fill of a free way ignores the victim; repeat hits
        push_access(16'h0000, 2'd3);
        push_access(16'h0000, 2'd1);
        push_access(16'hFFFF, 2'd2);
        push_access(16'hFFFF, 2'd0);
        // line 0 fills every way, then replacements by victim and repeat hits; then fills in lines 2 and 1
        push_access(16'h0004, 2'd0);
        push_access(16'h0008, 2'd1);
        push_access(16'h000C, 2'd2);
        push_access(16'h0010, 2'd3);
        push_access(16'h000C, 2'd0);
        push_access(16'h0010, 2'd1);
        push_access(16'h0000, 2'd2);
        push_access(16'h8000, 2'd1);
        push_access(16'h8000, 2'd3);
        push_access(16'hAAAA, 2'd2);
        push_access(16'h5555, 2'd1);
        push_access(16'h5555, 2'd0);
        queue_random(270);
        drain_accesses();

        send_idle_pct = 74;
        recv_idle_pct = 15;
        queue_random(280);
        drain_accesses();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_go   = 1'b1;
        queue_random(290);
        drain_accesses();

        while (expected_lookups.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d lookups checked: %0d hits, %0d fills, %0d of them replacing a full line",
                 n_results, n_hits, n_misses, n_evicts);
        if (n_errors == 0) begin
            $display("four_way_cache_lookup_fill_core: match");
        end else begin
            $display("four_way_cache_lookup_fill_core: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still expected", expected_lookups.size());
        $display("four_way_cache_lookup_fill_core: mismatch");
        $finish;
    end

endmodule
